@@ rtl/core/vwbp_pkg.sv @@
// ----------------------------------------------------------------------------
// vwbp_pkg
// Shared types, constants and helpers of the variable width bit packer.
// ----------------------------------------------------------------------------
package vwbp_pkg;

	localparam int MAX_FIELD_BITS = 64;
	localparam int ValW = 64;
	localparam int WidW = 7;
	localparam int BufW = MAX_FIELD_BITS + 8;
	localparam int MaxBytes = (MAX_FIELD_BITS + 7) / 8;
	localparam int CntW = $clog2(MaxBytes + 1);
	localparam int QDepth = 4;
	localparam int PtrW = $clog2(QDepth);

	typedef enum logic [2:0] {
		OP_MIN    = 3'd0,
		OP_REQ    = 3'd1,
		OP_CUSTOM = 3'd2,
		OP_FLUSH  = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_DIR  = 2'd0,
		KIND_BYTE = 2'd1,
		KIND_END  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		CMD_PACK  = 2'd0,
		CMD_FLUSH = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_BYTES = 2'd1,
		ST_END   = 2'd2
	} bstate_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [ValW-1:0]   value;
		logic [WidW-1:0]   width;
		logic [2:0]        etype;
	} entry_t;

	typedef struct packed {
		kind_t        kind;
		logic [2:0]   entry_type;
		logic [31:0]  bit_offset;
		logic [6:0]   bit_size;
		logic [7:0]   data_byte;
		logic [29:0]  total_bytes;
		logic         last;
	} result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	function automatic logic [WidW-1:0] min_width(input logic [ValW-1:0] v);
		logic [ValW-1:0] t;
		logic [5:0]      n;
		t = v;
		n = '0;
		if (t[63:32] != '0) begin
			n[5] = 1'b1;
			t = t >> 32;
		end
		if (t[31:16] != '0) begin
			n[4] = 1'b1;
			t = t >> 16;
		end
		if (t[15:8] != '0) begin
			n[3] = 1'b1;
			t = t >> 8;
		end
		if (t[7:4] != '0) begin
			n[2] = 1'b1;
			t = t >> 4;
		end
		if (t[3:2] != '0) begin
			n[1] = 1'b1;
			t = t >> 2;
		end
		if (t[1] != 1'b0) begin
			n[0] = 1'b1;
		end
		return {1'b0, n} + 7'd1;
	endfunction

endpackage

@@ rtl/core/vwbp_front.sv @@
// ----------------------------------------------------------------------------
// vwbp_front
// Accept input transactions, decode the operation, size the field and queue
// a command for the back end.
// ----------------------------------------------------------------------------
module vwbp_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [79:0]          s_tdata,
	input  logic [2:0]           s_tuser,
	input  vwbp_pkg::qstat_t     q_stat,
	output logic                 push,
	output vwbp_pkg::entry_t     push_entry
);
	import vwbp_pkg::*;

	logic [ValW-1:0] value;
	logic [WidW-1:0] req;
	logic [2:0]      tag;
	logic [WidW-1:0] mw;
	logic [WidW-1:0] w;
	logic [ValW-1:0] mask;
	logic            op_ok;
	cmd_t            cmd;
	logic [2:0]      etype;

	assign value = s_tdata[63:0];
	assign req   = s_tdata[70:64];
	assign tag   = s_tdata[73:71];
	assign mw    = min_width(value);

	always_comb begin
		w = mw;
		if (s_tuser != OP_MIN && req > mw) begin
			w = req;
		end
		if (w > WidW'(MAX_FIELD_BITS)) begin
			w = WidW'(MAX_FIELD_BITS);
		end
		if (w >= WidW'(ValW)) begin
			mask = '1;
		end else begin
			mask = ~({ValW{1'b1}} << w);
		end
	end

	always_comb begin
		etype = tag;
		if (s_tuser == OP_CUSTOM) begin
			if (value[63:8] == '0) begin
				etype = 3'd0;
			end else if (value[63:16] == '0) begin
				etype = 3'd1;
			end else if (value[63:32] == '0) begin
				etype = 3'd2;
			end else begin
				etype = 3'd3;
			end
		end
	end

	always_comb begin
		op_ok = 1'b1;
		cmd   = CMD_PACK;
		case (s_tuser)
			OP_MIN, OP_REQ, OP_CUSTOM: cmd = CMD_PACK;
			OP_FLUSH:                  cmd = CMD_FLUSH;
			OP_CLEAR:                  cmd = CMD_CLEAR;
			default:                   op_ok = 1'b0;
		endcase
	end

	assign s_tready         = !q_stat.full;
	assign push             = s_tvalid && !q_stat.full && op_ok;
	assign push_entry.cmd   = cmd;
	assign push_entry.value = value & mask;
	assign push_entry.width = w;
	assign push_entry.etype = etype;

endmodule

@@ rtl/core/vwbp_queue.sv @@
// ----------------------------------------------------------------------------
// vwbp_queue
// Small command queue between the front and back ends.
// ----------------------------------------------------------------------------
module vwbp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  vwbp_pkg::entry_t     push_entry,
	input  logic                 pop,
	output vwbp_pkg::entry_t     head,
	output vwbp_pkg::qstat_t     q_stat
);
	import vwbp_pkg::*;

	entry_t        mem_q [QDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == (PtrW+1)'(QDepth));
	assign q_stat.empty = (cnt_q == '0);

endmodule

@@ rtl/core/vwbp_back.sv @@
// ----------------------------------------------------------------------------
// vwbp_back
// Execute queued commands: keep the stream position and partial byte, and
// emit directory records, data bytes and end records one per cycle unless m_tready stalls the output.
// ----------------------------------------------------------------------------
module vwbp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vwbp_pkg::entry_t     head,
	input  vwbp_pkg::qstat_t     q_stat,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output vwbp_pkg::result_t    res
);
	import vwbp_pkg::*;

	bstate_t          state_q;
	bstate_t          state_d;
	logic [31:0]      bp_q;
	logic [7:0]       part_q;
	logic [BufW-1:0]  buf_q;
	logic [CntW-1:0]  cnt_q;
	logic [29:0]      tot_q;
	logic             out_valid_q;
	result_t          out_q;

	logic             adv;
	logic [2:0]       ph;
	logic [BufW-1:0]  buf_new;
	logic [WidW-1:0]  nb;
	logic [CntW-1:0]  nbytes;
	logic [7:0]       rem_byte;
	logic [29:0]      tot_new;
	logic             emit;
	result_t          res_d;

	assign adv      = !out_valid_q || m_tready;
	assign ph       = bp_q[2:0];
	assign buf_new  = (BufW'(head.value[MAX_FIELD_BITS-1:0]) << ph) | BufW'(part_q);
	assign nb       = WidW'(ph) + head.width;
	assign nbytes   = CntW'(nb >> 3);
	assign rem_byte = 8'(buf_new >> {nbytes, 3'b000});
	assign tot_new  = 30'(bp_q >> 3) + 30'(ph != 3'd0);

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (head.cmd)
						CMD_PACK: begin
							if (adv) begin
								pop     = 1'b1;
								state_d = (nbytes != '0) ? ST_BYTES : ST_IDLE;
							end
						end
						CMD_FLUSH: begin
							if (adv) begin
								pop     = 1'b1;
								state_d = (ph != 3'd0) ? ST_END : ST_IDLE;
							end
						end
						CMD_CLEAR: pop = 1'b1;
						default:   pop = 1'b0;
					endcase
				end
			end
			ST_BYTES: begin
				if (adv && cnt_q == CntW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_END: begin
				if (adv) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					case (head.cmd)
						CMD_PACK: begin
							emit             = 1'b1;
							res_d.kind       = KIND_DIR;
							res_d.entry_type = head.etype;
							res_d.bit_offset = bp_q;
							res_d.bit_size   = head.width;
							res_d.last       = (nbytes == '0);
						end
						CMD_FLUSH: begin
							emit = 1'b1;
							if (ph != 3'd0) begin
								res_d.kind      = KIND_BYTE;
								res_d.data_byte = part_q;
							end else begin
								res_d.kind        = KIND_END;
								res_d.total_bytes = tot_new;
								res_d.last        = 1'b1;
							end
						end
						default: emit = 1'b0;
					endcase
				end
			end
			ST_BYTES: begin
				emit            = 1'b1;
				res_d.kind      = KIND_BYTE;
				res_d.data_byte = buf_q[7:0];
				res_d.last      = (cnt_q == CntW'(1));
			end
			ST_END: begin
				emit              = 1'b1;
				res_d.kind        = KIND_END;
				res_d.total_bytes = tot_q;
				res_d.last        = 1'b1;
			end
			default: emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			bp_q        <= '0;
			part_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				out_valid_q <= emit;
			end
			if (pop) begin
				case (head.cmd)
					CMD_PACK: begin
						bp_q   <= bp_q + 32'(head.width);
						part_q <= rem_byte;
						cnt_q  <= nbytes;
					end
					default: begin
						bp_q   <= '0;
						part_q <= '0;
					end
				endcase
			end else if (state_q == ST_BYTES && adv) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res_d;
		end
		if (pop && head.cmd == CMD_PACK) begin
			buf_q <= buf_new;
		end else if (state_q == ST_BYTES && adv) begin
			buf_q <= buf_q >> 8;
		end
		if (pop && head.cmd == CMD_FLUSH) begin
			tot_q <= tot_new;
		end
	end

	assign m_tvalid = out_valid_q;
	assign res      = out_q;

endmodule

@@ rtl/core/variable_width_bit_packer_unit.sv @@
// ----------------------------------------------------------------------------
// variable_width_bit_packer_unit
// LSB-first variable width bit packer with a streaming input and output.
// ----------------------------------------------------------------------------
// Each pack transaction yields one directory record and then one data byte
// per byte it completes, so it yields 1 + (bit_position mod 8 + width) / 8
// results in all, at most 9; a flush yields one or two results and a clear
// none. The single output register of the back end emits one result per
// cycle while m_tready does not stall it. A four-entry command queue lets
// input transactions be taken while results are still going out, and codes
// 5 to 7 are dropped at input.
module variable_width_bit_packer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// value[63:0], requested_width[70:64], type_tag[73:71], zero fill
	input  logic [79:0] s_tdata,
	// operation[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// entry_type[2:0], bit_offset[34:3], bit_size[41:35], data_byte[49:42],
	// total_bytes[79:50]
	output logic [79:0] m_tdata,
	// record_kind[1:0]
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);
	import vwbp_pkg::*;

	qstat_t  q_stat;
	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  head;
	result_t res;

	vwbp_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	vwbp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	vwbp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {res.total_bytes, res.data_byte, res.bit_size, res.bit_offset,
		res.entry_type};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_END |-> m_tlast)
		else $error("end record without last");

	a_dir_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_DIR |-> m_tdata[79:42] == '0)
		else $error("directory record carries byte or total");

	a_push_seen: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !q_stat.empty)
		else $error("queued command lost");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

endmodule
